// File: src/mtrb_pkg.sv
// shared types, widths and operation codes of the rightmost-below min tree
`timescale 1ns / 1ps

package mtrb_pkg;

    localparam int SLOT_W    = 12;
    localparam int VAL_W     = 48;
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    localparam logic [S_TUSER_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [S_TUSER_W-1:0] OP_SET   = 2'd1;
    localparam logic [S_TUSER_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] min;
    } t_node;

endpackage

// File: src/min_tree_rightmost_below.sv
// binary min tree over signed slots with rightmost-below-threshold search
`timescale 1ns / 1ps
// Usage: items arrive on the s-side stream. tuser carries the operation (clear all
// slots, set one slot, query rightmost slot below a threshold), tdata carries the
// slot index and the 48-bit value. Each item gives exactly one result on the m-side
// stream: tuser is the found flag, tdata the matching slot (zero for clear, set and
// a query that misses).
// Sequencing: the tree lives in one node memory with two registered read ports; the
// sequencer walks it one level at a time with one shared comparator.
//   set:   descend to the leaf and write it, then read both children and refresh
//          each minimum on the way back up (L = clog2(SLOTS) levels, 12 by default)
//   query: read and check the root, then read and check one right child per level
//   clear: a clearing pass over all 2*SLOTS-1 nodes of the node memory
// One item is in flight at a time; s_tready is high only while the sequencer idles.
// Reset: synchronous, active low. After reset the same clearing pass over the
// node memory runs before the first item is taken.
// Stall: the result sits in an output register; a new item may be accepted while
// it waits, and that item's result is held back until the register is taken.
module min_tree_rightmost_below
    import mtrb_pkg::*;
#(
    parameter int SLOTS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [11:0] slot, [59:12] value, [63:60] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [11:0] found_slot, [15:12] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [0] found
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    localparam int NODES  = 2 * SLOTS - 1;
    localparam int NW     = $clog2(NODES);
    localparam int LW     = $clog2(SLOTS);
    localparam int LEVELS = $clog2(SLOTS);
    localparam int DW     = $clog2(LEVELS + 1);
    localparam int IW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW     = (LW > SLOT_W) ? LW : SLOT_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_DESC     = 4'd2;
    localparam logic [3:0] S_LEAF     = 4'd3;
    localparam logic [3:0] S_RD       = 4'd4;
    localparam logic [3:0] S_UP       = 4'd5;
    localparam logic [3:0] S_QROOT    = 4'd6;
    localparam logic [3:0] S_QROOTCHK = 4'd7;
    localparam logic [3:0] S_QRD      = 4'd8;
    localparam logic [3:0] S_QCHK     = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]              r_state;
    logic [NW-1:0]           r_clr_addr;
    logic                    r_clr_op;
    logic [DW-1:0]           r_depth;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [SLOT_W-1:0]       r_out_slot;
    logic                    r_res_found;
    logic [SLOT_W-1:0]       r_res_slot;
    logic [NW-1:0]           r_x;
    logic [LW-1:0]           r_l;
    logic [LW-1:0]           r_r;
    logic signed [VAL_W-1:0] r_key;
    logic [SLOT_W-1:0]       r_slot;
    logic [NW-1:0]           r_stk_x  [LEVELS];
    logic [NW-1:0]           r_stk_rc [LEVELS];
    t_node                   r_mem    [NODES];
    t_node                   r_rd_a;
    t_node                   r_rd_b;

    logic [S_TUSER_W-1:0]    w_in_op;
    logic [SLOT_W-1:0]       w_in_slot;
    logic signed [VAL_W-1:0] w_in_value;
    logic                    w_slot_ok;
    logic [LW:0]             w_sum;
    logic [LW-1:0]           w_mid;
    logic [LW-1:0]           w_mid_p1;
    logic [LW:0]             w_half;
    logic [NW-1:0]           w_lc;
    logic [NW-1:0]           w_rc;
    logic                    w_go_left;
    logic [DW-1:0]           w_top;
    logic [NW-1:0]           w_top_x;
    logic [NW-1:0]           w_top_rc;
    logic signed [VAL_W-1:0] w_cmp_b;
    logic                    w_lt;
    logic                    w_take_right;
    logic [LW-1:0]           w_new_l;
    logic [LW-1:0]           w_new_r;
    t_node                   w_refresh;
    logic                    w_we;
    logic [NW-1:0]           w_waddr;
    t_node                   w_wdata;
    logic [NW-1:0]           w_ra;
    logic [NW-1:0]           w_rb;
    logic                    w_out_load;

    assign w_in_op    = i_s_tuser[1:0];
    assign w_in_slot  = i_s_tdata[SLOT_W-1:0];
    assign w_in_value = $signed(i_s_tdata[SLOT_W+VAL_W-1:SLOT_W]);
    assign w_slot_ok  = (32'(w_in_slot) < 32'(SLOTS));

    // child indices of the preorder layout for the node in r_x covering [r_l, r_r]
    assign w_sum     = {1'b0, r_l} + {1'b0, r_r};
    assign w_mid     = w_sum[LW:1];
    assign w_mid_p1  = w_mid + 1'b1;
    assign w_half    = {1'b0, w_mid} - {1'b0, r_l} + 1'b1;
    assign w_lc      = r_x + 1'b1;
    assign w_rc      = r_x + NW'({w_half, 1'b0});
    assign w_go_left = (CW'(r_slot) <= CW'(w_mid));

    assign w_top    = r_depth - 1'b1;
    assign w_top_x  = r_stk_x[w_top[IW-1:0]];
    assign w_top_rc = r_stk_rc[w_top[IW-1:0]];

    // shared comparator: child against child on the way up, node against key in a query
    assign w_cmp_b = (r_state == S_UP) ? r_rd_b.min : r_key;
    assign w_lt    = (r_rd_a.min < w_cmp_b);

    assign w_take_right = r_rd_a.valid && w_lt;
    assign w_new_l      = w_take_right ? w_mid_p1 : r_l;
    assign w_new_r      = w_take_right ? r_r : w_mid;

    // result register loads in S_DONE when it is empty or being taken this cycle
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_refresh.valid = r_rd_a.valid || r_rd_b.valid;
        if (r_rd_a.valid && r_rd_b.valid) begin
            w_refresh.min = w_lt ? r_rd_a.min : r_rd_b.min;
        end else if (r_rd_b.valid) begin
            w_refresh.min = r_rd_b.min;
        end else begin
            w_refresh.min = r_rd_a.min;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_x;
        w_wdata = '0;
        w_ra    = r_x;
        w_rb    = w_top_rc;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            S_LEAF: begin
                w_we          = 1'b1;
                w_wdata.valid = 1'b1;
                w_wdata.min   = r_key;
            end
            S_RD: begin
                w_ra = w_top_x + 1'b1;
            end
            S_UP: begin
                w_we    = 1'b1;
                w_waddr = w_top_x;
                w_wdata = w_refresh;
            end
            S_QROOT: begin
                w_ra = '0;
            end
            S_QRD: begin
                w_ra = w_rc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_depth <= '0;
                        case (w_in_op)
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_op   <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            OP_SET:   r_state <= w_slot_ok ? S_DESC : S_DONE;
                            OP_QUERY: r_state <= S_QROOT;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == NW'(NODES - 1)) begin
                        r_state <= r_clr_op ? S_DONE : S_IDLE;
                    end
                end
                S_DESC: begin
                    if (r_l < r_r) begin
                        r_depth <= r_depth + 1'b1;
                    end else begin
                        r_state <= S_LEAF;
                    end
                end
                S_LEAF: r_state <= S_RD;
                S_RD:   r_state <= S_UP;
                S_UP: begin
                    r_depth <= w_top;
                    r_state <= (w_top == '0) ? S_DONE : S_RD;
                end
                S_QROOT:    r_state <= S_QROOTCHK;
                S_QROOTCHK: r_state <= (r_rd_a.valid && w_lt) ? S_QRD : S_DONE;
                S_QRD:      r_state <= S_QCHK;
                S_QCHK: begin
                    if (!(w_new_l < w_new_r)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_QRD;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_clr_op <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_key       <= w_in_value;
                r_slot      <= w_in_slot;
                r_x         <= '0;
                r_l         <= '0;
                r_r         <= LW'(SLOTS - 1);
                r_res_found <= 1'b0;
                r_res_slot  <= '0;
            end
            S_DESC: begin
                if (r_l < r_r) begin
                    r_stk_x[r_depth[IW-1:0]]  <= r_x;
                    r_stk_rc[r_depth[IW-1:0]] <= w_rc;
                    if (w_go_left) begin
                        r_x <= w_lc;
                        r_r <= w_mid;
                    end else begin
                        r_x <= w_rc;
                        r_l <= w_mid_p1;
                    end
                end
            end
            S_QCHK: begin
                r_x <= w_take_right ? w_rc : w_lc;
                r_l <= w_new_l;
                r_r <= w_new_r;
                if (!(w_new_l < w_new_r)) begin
                    r_res_found <= 1'b1;
                    r_res_slot  <= SLOT_W'(w_new_l);
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    r_out_found <= r_res_found;
                    r_out_slot  <= r_res_slot;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_slot);
    assign o_m_tuser  = M_TUSER_W'(r_out_found);

endmodule

// File: src/mtrb_checker.sv
// port-level checker for the rightmost-below min tree, bound to the top level
`timescale 1ns / 1ps

module mtrb_checker
    import mtrb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser
);

    // reset starts the clearing pass: nothing offered, nothing taken
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !o_s_tready))
        else $error("output valid or input ready right after reset");

    // one transaction at a time: ready drops after an accepted item
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready stayed high after an accepted item");

    // a miss or a non-query result carries slot zero
    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[SLOT_W-1:0] == '0))
        else $error("result without a match has a nonzero slot");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind min_tree_rightmost_below mtrb_checker u_mtrb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: dv/min_tree_rightmost_below_tb.sv
// self-checking testbench for the rightmost-below min tree
`timescale 1ns / 1ps

module min_tree_rightmost_below_tb
    import mtrb_pkg::*;
;

    localparam int N_SLOTS      = 4096;
    localparam int N_RANDOM     = 2000;
    localparam int QUIET_TAIL   = 150;
    localparam int MAX_REPORTS  = 100;
    localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;

    typedef struct {
        logic [S_TUSER_W-1:0]    op;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] value;
        bit                      drain;
    } t_tree_op;

    typedef struct {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_hit;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // [11:0] slot, [59:12] value, [63:60] zero
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    // [1:0] op
    logic [S_TUSER_W-1:0] i_s_tuser = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [11:0] found_slot, [15:12] zero
    logic [M_TDATA_W-1:0] o_m_tdata;
    // [0] found
    logic [M_TUSER_W-1:0] o_m_tuser;

    t_tree_op pending_items[$];
    t_hit     expected_hits[$];
    t_tree_op cur_item;
    int       total_items = 0;
    int       accepted_count = 0;
    int       errors = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    logic     quiet = 1'b0;

    // flat view of the slots: full flag and stored value
    bit                      slot_full [N_SLOTS];
    logic signed [VAL_W-1:0] slot_val  [N_SLOTS];

    always #4 i_clk = ~i_clk;

    min_tree_rightmost_below #(
        .SLOTS(N_SLOTS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    function automatic t_hit predict_rightmost_below(t_tree_op it);
        t_hit h;
        h.found = 1'b0;
        h.slot  = '0;
        case (it.op)
            OP_CLEAR: begin
                for (int i = 0; i < N_SLOTS; i++) slot_full[i] = 1'b0;
            end
            OP_SET: begin
                if (it.slot < N_SLOTS) begin
                    slot_full[it.slot] = 1'b1;
                    slot_val[it.slot]  = it.value;
                end
            end
            OP_QUERY: begin
                for (int i = N_SLOTS - 1; i >= 0; i--) begin
                    if (slot_full[i] && slot_val[i] < it.value) begin
                        h.found = 1'b1;
                        h.slot  = i[SLOT_W-1:0];
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    task automatic add_item(logic [S_TUSER_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic signed [VAL_W-1:0] value, bit drain = 1'b0);
        t_tree_op it;
        it.op    = op;
        it.slot  = slot;
        it.value = value;
        it.drain = drain;
        pending_items.insert(pending_items.size(), it);
        total_items++;
    endtask

    // mostly small values so thresholds land among stored ones, plus full-width random values and extremes
    function automatic logic signed [VAL_W-1:0] rand_value();
        logic [63:0]             r;
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1: begin
                r = {$urandom, $urandom};
                v = r[VAL_W-1:0];
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 48'sd1;
                    3: v = VAL_MAX - 48'sd1;
                    4: v = '0;
                    default: v = -48'sd1;
                endcase
            end
            default: begin
                v = VAL_W'($urandom_range(0, 127));
                v = v - 48'sd64;
            end
        endcase
        return v;
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        case ($urandom_range(0, 2))
            0: return SLOT_W'($urandom_range(0, N_SLOTS - 1));
            1: return SLOT_W'($urandom_range(0, 31));
            default: return SLOT_W'($urandom_range(N_SLOTS - 32, N_SLOTS - 1));
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        t_tree_op nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            quiet <= (pending_items.size() < QUIET_TAIL);
            if (!i_s_tvalid || o_s_tready) begin
                if (i_s_tvalid) begin
                    expected_hits.insert(expected_hits.size(),
                                         predict_rightmost_below(cur_item));
                    accepted_count++;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (pending_items[0].drain && expected_hits.size() != 0) begin
                    // hold off until every outstanding result has come back
                    i_s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 10);
                    i_s_tvalid <= 1'b0;
                end else begin
                    nxt = pending_items.pop_front();
                    cur_item = nxt;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {4'b0, nxt.value, nxt.slot};
                    i_s_tuser  <= nxt.op;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_hit want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_hits.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: extra result, expected none, actual found=%0b slot=%0d",
                                 $time, o_m_tuser[0], o_m_tdata[SLOT_W-1:0]);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_m_tuser[0] !== want.found ||
                        o_m_tdata[SLOT_W-1:0] !== want.slot) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: expected found=%0b slot=%0d, actual %0b %0d",
                                     $time, want.found, want.slot,
                                     o_m_tuser[0], o_m_tdata[SLOT_W-1:0]);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int r;
        // directed: empty tree, value extremes, overwrite, unused op, clear
        add_item(OP_QUERY, 12'd0,    VAL_MAX);
        add_item(OP_SET,   12'd0,    VAL_MIN);
        add_item(OP_SET,   12'd4095, VAL_MAX);
        add_item(OP_QUERY, 12'd0,    VAL_MAX);
        add_item(OP_QUERY, 12'd0,    VAL_MIN);
        add_item(OP_QUERY, 12'd0,    VAL_MIN + 48'sd1);
        add_item(OP_SET,   12'd2048, 48'sd0);
        add_item(OP_QUERY, 12'd0,    48'sd1);
        add_item(OP_SET,   12'd4095, -48'sd1);
        add_item(OP_QUERY, 12'd0,    48'sd0);
        add_item(OP_SET,   12'd2047, -48'sd5);
        add_item(OP_QUERY, 12'd0,    -48'sd4);
        add_item(OP_UNUSED, 12'd4095, VAL_MIN);
        add_item(OP_QUERY, 12'd0,    VAL_MAX);
        add_item(OP_SET,   12'hAAA,  48'sh5555_5555_5555);
        add_item(OP_SET,   12'h555,  48'shAAAA_AAAA_AAAA);
        add_item(OP_QUERY, 12'hFFF,  48'sh5555_5555_5556);
        add_item(OP_CLEAR, 12'hFFF,  VAL_MAX);
        add_item(OP_QUERY, 12'd0,    VAL_MAX);
        add_item(OP_SET,   12'd1,    48'sd5);
        add_item(OP_QUERY, 12'd0,    48'sd6);
        add_item(OP_QUERY, 12'd0,    48'sd5);

        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 199);
            if (r < 2)
                add_item(OP_CLEAR, rand_slot(), rand_value(), n == N_RANDOM / 2);
            else if (r < 6)
                add_item(OP_UNUSED, rand_slot(), rand_value(), n == N_RANDOM / 2);
            else if (r < 104)
                add_item(OP_SET, rand_slot(), rand_value(), n == N_RANDOM / 2);
            else
                add_item(OP_QUERY, rand_slot(), rand_value(), n == N_RANDOM / 2);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (errors == 0)
            $display("min_tree_rightmost_below_tb passed");
        else
            $display("min_tree_rightmost_below_tb failed");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("min_tree_rightmost_below_tb failed");
        $finish;
    end

endmodule

// File: filelist.f
src/mtrb_pkg.sv
src/min_tree_rightmost_below.sv
src/mtrb_checker.sv
dv/min_tree_rightmost_below_tb.sv
